FILE: rtl/ellipse_midpoint_rasterizer_assert.svh
// assertion helpers used by the rasterizer controller
// each macro expects clk and arst_n in the enclosing module
`ifndef ELLIPSE_MIDPOINT_RASTERIZER_ASSERT_SVH
`define ELLIPSE_MIDPOINT_RASTERIZER_ASSERT_SVH

// consequent in the same cycle
`define EMR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define EMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/emr_pkg.sv
package emr_pkg;

	localparam int FIELD_W     = 12;
	localparam int POS_W       = 14;
	localparam int COLOR_W     = 32;
	localparam int PENW_W      = 8;
	localparam int ALPHA_LSB   = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_USED_W  = 3 * POS_W + COLOR_W + PENW_W;
	localparam int OUT_TDATA_W = 88;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
	localparam int CNT_W       = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_COLOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEN_WIDTH   = 2'd2;

	localparam logic [COLOR_W-1:0] PEN_COLOR_RST   = 32'hFF00_0000;
	localparam logic [COLOR_W-1:0] BRUSH_COLOR_RST = 32'h0000_0000;
	localparam logic [PENW_W-1:0]  PEN_WIDTH_RST   = 8'd1;
	localparam logic [PENW_W-1:0]  SPAN_WIDTH      = 8'd1;

	localparam logic [CNT_W-1:0] N_START     = 3'd2;
	localparam logic [CNT_W-1:0] N_STEP      = 3'd4;
	localparam logic [CNT_W-1:0] N_STEP_FILL = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_R1   = 2'd1,
		PH_R2   = 2'd2
	} phase_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_RX,
		ST_SQ_RY,
		ST_RX2RY,
		ST_INIT,
		ST_R1B,
		ST_R1C,
		ST_R2B,
		ST_R2C,
		ST_EMIT,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_E6
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQ_RX,
		OP_SQ_RY,
		OP_RX2RY,
		OP_INIT,
		OP_R1A,
		OP_R1B,
		OP_R1C,
		OP_R2A,
		OP_R2B,
		OP_R2C,
		OP_E1,
		OP_E2,
		OP_E3,
		OP_E4,
		OP_E5,
		OP_E6
	} dp_op_t;

	typedef enum logic [2:0] {
		SL_SPAN_B = 3'd0,
		SL_SPAN_T = 3'd1,
		SL_XR_B   = 3'd2,
		SL_XL_B   = 3'd3,
		SL_XL_T   = 3'd4,
		SL_XR_T   = 3'd5
	} slot_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;
		slot_t  slot;
		logic   last;
		logic   done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic fill_en;
		logic zero_radius;
		logic yt_lt_xt;
		logic y_le_zero;
	} dp_status_t;

endpackage

FILE: rtl/emr_ctrl.sv
`include "ellipse_midpoint_rasterizer_assert.svh"

module emr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_command,
	output logic                   in_ready,
	input  emr_pkg::dp_status_t    st,
	output emr_pkg::ctrl_cmd_t     cmd
);

	emr_pkg::state_t state_q, state_d;
	emr_pkg::phase_t phase_q, phase_d;
	logic            start_q;
	logic [emr_pkg::CNT_W-1:0] cnt_q;

	logic [emr_pkg::CNT_W-1:0] n_items;
	logic [emr_pkg::CNT_W-1:0] cnt_off;
	logic            last_now;
	logic            done_cond;
	logic            enter_r2;
	logic            emit_now;
	logic            accept;
	emr_pkg::phase_t phase_end;
	emr_pkg::slot_t  slot;

	assign accept   = in_valid && in_ready;
	assign emit_now = (state_q == emr_pkg::ST_EMIT) && st.out_free;

	// next result's slot and last/done flags, and end phase
	always_comb begin
		cnt_off   = cnt_q + emr_pkg::CNT_W'(2);
		n_items   = start_q ? emr_pkg::N_START :
		            (st.fill_en ? emr_pkg::N_STEP_FILL : emr_pkg::N_STEP);
		last_now  = (cnt_q == n_items - emr_pkg::CNT_W'(1));
		enter_r2  = !start_q && (phase_q == emr_pkg::PH_R1) && st.yt_lt_xt && !st.y_le_zero;
		if (start_q) begin
			slot      = (cnt_q == '0) ? emr_pkg::SL_XR_B : emr_pkg::SL_XR_T;
			done_cond = st.zero_radius;
			phase_end = st.zero_radius ? emr_pkg::PH_IDLE : emr_pkg::PH_R1;
		end else if (phase_q == emr_pkg::PH_R1) begin
			slot      = st.fill_en ? emr_pkg::slot_t'(cnt_q) : emr_pkg::slot_t'(cnt_off);
			done_cond = st.yt_lt_xt && st.y_le_zero;
			phase_end = !st.yt_lt_xt ? emr_pkg::PH_R1 :
			            (st.y_le_zero ? emr_pkg::PH_IDLE : emr_pkg::PH_R2);
		end else begin
			slot      = st.fill_en ? emr_pkg::slot_t'(cnt_q) : emr_pkg::slot_t'(cnt_off);
			done_cond = st.y_le_zero;
			phase_end = st.y_le_zero ? emr_pkg::PH_IDLE : emr_pkg::PH_R2;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			emr_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!in_command) begin
						state_d = emr_pkg::ST_SQ_RX;
					end else if (phase_q == emr_pkg::PH_R1) begin
						state_d = emr_pkg::ST_R1B;
					end else if (phase_q == emr_pkg::PH_R2) begin
						state_d = emr_pkg::ST_R2B;
					end
				end
			end
			emr_pkg::ST_SQ_RX: state_d = emr_pkg::ST_SQ_RY;
			emr_pkg::ST_SQ_RY: state_d = emr_pkg::ST_RX2RY;
			emr_pkg::ST_RX2RY: state_d = emr_pkg::ST_INIT;
			emr_pkg::ST_INIT:  state_d = emr_pkg::ST_EMIT;
			emr_pkg::ST_R1B:   state_d = emr_pkg::ST_R1C;
			emr_pkg::ST_R1C:   state_d = emr_pkg::ST_EMIT;
			emr_pkg::ST_R2B:   state_d = emr_pkg::ST_R2C;
			emr_pkg::ST_R2C:   state_d = emr_pkg::ST_EMIT;
			emr_pkg::ST_EMIT: begin
				if (emit_now && last_now) begin
					phase_d = phase_end;
					state_d = enter_r2 ? emr_pkg::ST_E1 : emr_pkg::ST_IDLE;
				end
			end
			emr_pkg::ST_E1: state_d = emr_pkg::ST_E2;
			emr_pkg::ST_E2: state_d = emr_pkg::ST_E3;
			emr_pkg::ST_E3: state_d = emr_pkg::ST_E4;
			emr_pkg::ST_E4: state_d = emr_pkg::ST_E5;
			emr_pkg::ST_E5: state_d = emr_pkg::ST_E6;
			emr_pkg::ST_E6: state_d = emr_pkg::ST_IDLE;
			default:        state_d = emr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == emr_pkg::ST_IDLE);
		cmd.emit = emit_now;
		cmd.slot = slot;
		cmd.last = last_now;
		cmd.done = last_now && done_cond;
		case (state_q)
			emr_pkg::ST_IDLE: begin
				if (!in_valid) begin
					cmd.op = emr_pkg::OP_NOP;
				end else if (!in_command) begin
					cmd.op = emr_pkg::OP_LOAD;
				end else if (phase_q == emr_pkg::PH_R1) begin
					cmd.op = emr_pkg::OP_R1A;
				end else if (phase_q == emr_pkg::PH_R2) begin
					cmd.op = emr_pkg::OP_R2A;
				end else begin
					cmd.op = emr_pkg::OP_NOP;
				end
			end
			emr_pkg::ST_SQ_RX: cmd.op = emr_pkg::OP_SQ_RX;
			emr_pkg::ST_SQ_RY: cmd.op = emr_pkg::OP_SQ_RY;
			emr_pkg::ST_RX2RY: cmd.op = emr_pkg::OP_RX2RY;
			emr_pkg::ST_INIT:  cmd.op = emr_pkg::OP_INIT;
			emr_pkg::ST_R1B:   cmd.op = emr_pkg::OP_R1B;
			emr_pkg::ST_R1C:   cmd.op = emr_pkg::OP_R1C;
			emr_pkg::ST_R2B:   cmd.op = emr_pkg::OP_R2B;
			emr_pkg::ST_R2C:   cmd.op = emr_pkg::OP_R2C;
			emr_pkg::ST_E1:    cmd.op = emr_pkg::OP_E1;
			emr_pkg::ST_E2:    cmd.op = emr_pkg::OP_E2;
			emr_pkg::ST_E3:    cmd.op = emr_pkg::OP_E3;
			emr_pkg::ST_E4:    cmd.op = emr_pkg::OP_E4;
			emr_pkg::ST_E5:    cmd.op = emr_pkg::OP_E5;
			emr_pkg::ST_E6:    cmd.op = emr_pkg::OP_E6;
			default:           cmd.op = emr_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= emr_pkg::ST_IDLE;
			phase_q <= emr_pkg::PH_IDLE;
			start_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (accept) begin
				start_q <= !in_command;
				cnt_q   <= '0;
			end else if (emit_now) begin
				cnt_q <= cnt_q + emr_pkg::CNT_W'(1);
			end
		end
	end

	`EMR_ASSERT_IMPLY(a_emit_needs_room, cmd.emit, st.out_free, "result issued into a full output register")
	`EMR_ASSERT_IMPLY(a_done_only_last, cmd.emit && cmd.done, cmd.last, "shape finished before last result")
	`EMR_ASSERT_NEXT(a_done_goes_idle, cmd.emit && cmd.done, phase_q == emr_pkg::PH_IDLE && state_q == emr_pkg::ST_IDLE, "finished shape left a live phase")
	`EMR_ASSERT_NEXT(a_region2_entry, state_q == emr_pkg::ST_E6, phase_q == emr_pkg::PH_R2 && state_q == emr_pkg::ST_IDLE, "region 2 set-up did not land in region 2")

endmodule

FILE: rtl/emr_datapath.sv
module emr_datapath #(
	parameter int COORD_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  emr_pkg::ctrl_cmd_t                    cmd,
	input  logic [emr_pkg::IN_TDATA_W-1:0]        in_tdata,
	input  logic                                  cfg_we,
	input  logic [emr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [emr_pkg::COLOR_W-1:0]           cfg_data,
	input  logic                                  out_ready,
	output emr_pkg::dp_status_t                   st,
	output logic                                  out_valid,
	output logic [emr_pkg::OUT_TDATA_W-1:0]       out_tdata,
	output logic [1:0]                            out_tuser,
	output logic                                  out_tlast
);

	localparam int CW  = (COORD_BITS < emr_pkg::FIELD_W) ? COORD_BITS : emr_pkg::FIELD_W;
	localparam int RW  = CW - 1;
	localparam int SW  = CW + 1;
	localparam int QW  = 2 * CW - 2;
	localparam int TW  = 3 * CW + 1;
	localparam int DW  = 4 * CW + 2;
	localparam int MA  = 2 * CW;
	localparam int MB  = 2 * CW + 4;
	localparam int PW  = MA + MB;
	localparam int PXW = emr_pkg::POS_W + 1;

	// configuration registers
	logic [emr_pkg::COLOR_W-1:0] pen_color_q;
	logic [emr_pkg::COLOR_W-1:0] brush_color_q;
	logic [emr_pkg::PENW_W-1:0]  pen_width_q;

	// shape state
	logic [CW-1:0]        centre_x_q, centre_y_q;
	logic [RW-1:0]        rx_q, ry_q;
	logic [QW-1:0]        rx2_q, ry2_q;
	logic signed [SW-1:0] step_x_q, step_y_q;
	logic signed [TW-1:0] xterm_q, yterm_q, aux_q;
	logic signed [DW-1:0] dec_q;
	logic [PW-1:0]        mul_q;
	logic signed [PW-1:0] acc_q;

	// output register
	logic                             out_valid_q;
	logic                             kind_q, done_q, last_q;
	logic [emr_pkg::POS_W-1:0]        xs_q, xe_q, y_q;
	logic [emr_pkg::COLOR_W-1:0]      color_q;
	logic [emr_pkg::PENW_W-1:0]       width_q;

	logic [CW-1:0]        ax, ay, bx, by, dx, dy, min_x, min_y;
	logic [RW-1:0]        rx, ry;
	logic [MA-1:0]        mul_a;
	logic [MB-1:0]        mul_b;
	logic                 mul_en;
	logic signed [TW-1:0] two_rx2, two_ry2;
	logic signed [DW-1:0] rx2_d, ry2_d;
	logic signed [PW-1:0] p_x4, num_fin, dec_fin;
	logic [SW-1:0]        ym;
	logic [SW-1:0]        tx;
	logic signed [PXW-1:0] cx_e, cy_e, sx_e, sy_e, xl, xr, yb, yt;
	logic                 is_span, is_left, is_top;

	assign ax = in_tdata[CW-1:0];
	assign ay = in_tdata[emr_pkg::FIELD_W +: CW];
	assign bx = in_tdata[2*emr_pkg::FIELD_W +: CW];
	assign by = in_tdata[3*emr_pkg::FIELD_W +: CW];

	assign dx    = (bx > ax) ? bx - ax : ax - bx;
	assign dy    = (by > ay) ? by - ay : ay - by;
	assign rx    = dx[CW-1:1];
	assign ry    = dy[CW-1:1];
	assign min_x = (ax < bx) ? ax : bx;
	assign min_y = (ay < by) ? ay : by;

	assign two_rx2 = $signed(TW'({rx2_q, 1'b0}));
	assign two_ry2 = $signed(TW'({ry2_q, 1'b0}));
	assign rx2_d   = $signed(DW'(rx2_q));
	assign ry2_d   = $signed(DW'(ry2_q));

	// region 2 entry operands: 2x+1 and y-1, both non-negative there
	assign tx = {step_x_q[SW-2:0], 1'b1};
	assign ym = step_y_q - SW'(1);

	assign p_x4    = $signed({mul_q[PW-3:0], 2'b00});
	assign num_fin = acc_q - p_x4;
	// divide by four, rounding toward zero
	assign dec_fin = (num_fin + $signed({{(PW-2){1'b0}}, {2{num_fin[PW-1]}}})) >>> 2;

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			emr_pkg::OP_SQ_RX: begin
				mul_a = MA'(rx_q);
				mul_b = MB'(rx_q);
			end
			emr_pkg::OP_SQ_RY: begin
				mul_a = MA'(ry_q);
				mul_b = MB'(ry_q);
			end
			emr_pkg::OP_RX2RY: begin
				mul_a = MA'(rx2_q);
				mul_b = MB'(ry_q);
			end
			emr_pkg::OP_E1: begin
				mul_a = MA'(tx);
				mul_b = MB'(tx);
			end
			emr_pkg::OP_E2: begin
				mul_a = MA'(ry2_q);
				mul_b = mul_q[MB-1:0];
			end
			emr_pkg::OP_E3: begin
				mul_a = MA'(ym);
				mul_b = MB'(ym);
			end
			emr_pkg::OP_E4: begin
				mul_a = MA'(rx2_q);
				mul_b = mul_q[MB-1:0];
			end
			emr_pkg::OP_E5: begin
				mul_a = MA'(rx2_q);
				mul_b = MB'(ry2_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= PW'(mul_a) * PW'(mul_b);
		end
		case (cmd.op)
			emr_pkg::OP_LOAD: begin
				centre_x_q <= min_x + CW'(rx);
				centre_y_q <= min_y + CW'(ry);
				rx_q       <= rx;
				ry_q       <= ry;
				step_x_q   <= '0;
				step_y_q   <= $signed(SW'(ry));
				xterm_q    <= '0;
			end
			emr_pkg::OP_SQ_RY: rx2_q <= mul_q[QW-1:0];
			emr_pkg::OP_RX2RY: ry2_q <= mul_q[QW-1:0];
			emr_pkg::OP_INIT: begin
				yterm_q <= $signed({mul_q[TW-2:0], 1'b0});
				dec_q   <= ry2_d + $signed(DW'(ry2_q >> 2)) - $signed(mul_q[DW-1:0]);
			end
			emr_pkg::OP_R1A: begin
				step_x_q <= step_x_q + SW'(1);
				xterm_q  <= xterm_q + two_ry2;
				aux_q    <= yterm_q - two_rx2;
			end
			emr_pkg::OP_R1B: dec_q <= dec_q + DW'(xterm_q) + ry2_d;
			emr_pkg::OP_R1C: begin
				if (!dec_q[DW-1]) begin
					step_y_q <= step_y_q - SW'(1);
					yterm_q  <= aux_q;
					dec_q    <= dec_q - DW'(aux_q);
				end
			end
			emr_pkg::OP_R2A: begin
				step_y_q <= step_y_q - SW'(1);
				yterm_q  <= yterm_q - two_rx2;
				aux_q    <= xterm_q + two_ry2;
			end
			emr_pkg::OP_R2B: dec_q <= dec_q + rx2_d - DW'(yterm_q);
			emr_pkg::OP_R2C: begin
				if (dec_q[DW-1] || (dec_q == '0)) begin
					step_x_q <= step_x_q + SW'(1);
					xterm_q  <= aux_q;
					dec_q    <= dec_q + DW'(aux_q);
				end
			end
			emr_pkg::OP_E3: acc_q <= $signed(mul_q);
			emr_pkg::OP_E5: acc_q <= acc_q + p_x4;
			emr_pkg::OP_E6: dec_q <= dec_fin[DW-1:0];
			default: ;
		endcase
	end

	// mirrored points around the centre
	assign cx_e = $signed(PXW'(centre_x_q));
	assign cy_e = $signed(PXW'(centre_y_q));
	assign sx_e = PXW'(step_x_q);
	assign sy_e = PXW'(step_y_q);
	assign xl   = cx_e - sx_e;
	assign xr   = cx_e + sx_e;
	assign yb   = cy_e + sy_e;
	assign yt   = cy_e - sy_e;

	assign is_span = (cmd.slot == emr_pkg::SL_SPAN_B) || (cmd.slot == emr_pkg::SL_SPAN_T);
	assign is_left = (cmd.slot == emr_pkg::SL_XL_B) || (cmd.slot == emr_pkg::SL_XL_T);
	assign is_top  = (cmd.slot == emr_pkg::SL_SPAN_T) || (cmd.slot == emr_pkg::SL_XL_T) ||
	                 (cmd.slot == emr_pkg::SL_XR_T);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q  <= is_span;
			xs_q    <= (is_span || is_left) ? xl[emr_pkg::POS_W-1:0] : xr[emr_pkg::POS_W-1:0];
			xe_q    <= is_left ? xl[emr_pkg::POS_W-1:0] : xr[emr_pkg::POS_W-1:0];
			y_q     <= is_top ? yt[emr_pkg::POS_W-1:0] : yb[emr_pkg::POS_W-1:0];
			color_q <= is_span ? brush_color_q : pen_color_q;
			width_q <= is_span ? emr_pkg::SPAN_WIDTH : pen_width_q;
			last_q  <= cmd.last;
			done_q  <= cmd.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			pen_color_q   <= emr_pkg::PEN_COLOR_RST;
			brush_color_q <= emr_pkg::BRUSH_COLOR_RST;
			pen_width_q   <= emr_pkg::PEN_WIDTH_RST;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					emr_pkg::CFG_PEN_COLOR:   pen_color_q   <= cfg_data;
					emr_pkg::CFG_BRUSH_COLOR: brush_color_q <= cfg_data;
					emr_pkg::CFG_PEN_WIDTH:   pen_width_q   <= cfg_data[emr_pkg::PENW_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign st.out_free    = !out_valid_q || out_ready;
	assign st.fill_en     = (brush_color_q[emr_pkg::COLOR_W-1:emr_pkg::ALPHA_LSB] != '0);
	assign st.zero_radius = (rx_q == '0) || (ry_q == '0);
	assign st.yt_lt_xt    = (yterm_q < xterm_q);
	assign st.y_le_zero   = step_y_q[SW-1] || (step_y_q == '0);

	assign out_valid = out_valid_q;
	assign out_tdata = {{emr_pkg::OUT_PAD_W{1'b0}}, width_q, color_q, y_q, xe_q, xs_q};
	assign out_tuser = {done_q, kind_q};
	assign out_tlast = last_q;

endmodule

FILE: rtl/ellipse_midpoint_rasterizer.sv
// midpoint ellipse rasterizer: outline stamp centres and optional fill spans
// s_axis: one transaction per command; tuser = 0 starts a shape from the two
//   corners in tdata, tuser = 1 advances the shape by one midpoint iteration
// m_axis: one transaction per result; tlast marks the final result of the
//   input transaction, tuser[1] marks the result that finishes the shape
// cfg: pen colour (0), brush colour (1), pen width (2); cfg_ready is always high
// one item at a time: s_axis_tready is high only while the sequencer is idle
// start: set-up through the shared multiplier (SQ_RX, SQ_RY, RX2RY, INIT), then 2 results
// step: update steps A, B and C, then 4 results (6 with a visible brush), one a cycle while m_axis accepts
// the step that leaves region 1 adds the region 2 set-up states E1 to E6 after its last result
// after the update finishes, the EMIT state loads the first result into the result register that drives m_axis
// a stalled m_axis holds the result register and the sequencer waits for it
// reset sets the cfg registers to their defaults, clears the output valid and leaves no shape active
module ellipse_midpoint_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// corner_ax, corner_ay, corner_bx, corner_by
	input  logic [emr_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
	// command
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// pos_x, span_end_x, pos_y, color, stamp_width, zero fill
	output logic [emr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	// kind, shape_done
	output logic [1:0]                             m_axis_tuser,
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [emr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [emr_pkg::COLOR_W-1:0]            cfg_data
);

	emr_pkg::ctrl_cmd_t  cmd;
	emr_pkg::dp_status_t st;

	assign cfg_ready = 1'b1;

	emr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.st         (st),
		.cmd        (cmd)
	);

	emr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_tdata  (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser),
		.out_tlast (m_axis_tlast)
	);

endmodule
